### hw/rtl/bsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsn_pkg;

    // Report field codes
    localparam logic [31:0] Unknown32     = 32'hFFFF_FFFF;
    localparam int          PresentBit    = 4;
    localparam logic [31:0] Milli         = 32'd1000;
    localparam logic [7:0]  FullThreshold = 8'd95;
    localparam logic [7:0]  FullPercent   = 8'd100;
    localparam logic [7:0]  NoPercent     = 8'd255;

    // Value lanes through the multiply and divide-by-1000 path
    localparam int NumLanes   = 4;
    localparam int LaneDesign = 0;
    localparam int LaneFull   = 1;
    localparam int LaneRemain = 2;
    localparam int LaneRate   = 3;

    // Divide by 1000, one 16-bit digit per step
    localparam int              DigitW     = 16;
    localparam int              RemW       = 10;
    localparam int              DivXW      = RemW + DigitW;
    localparam int              DivSteps   = 64 / DigitW;
    localparam int              DivStages  = 2 * DivSteps;
    localparam int              RecipW     = 27;
    localparam int              RecipShift = 36;
    localparam logic [RecipW-1:0] Recip1000 = 27'd68719477;

    // Percent divider: one prep stage, then one quotient bit per stage
    localparam int PctQuoW   = 7;
    localparam int PctNumW   = 39;
    localparam int PctStages = PctQuoW + 1;

    // Pipeline stage map
    localparam int StMul     = 1;
    localparam int StDiv0    = StMul + 1;
    localparam int StPct0    = StDiv0 + DivStages;
    localparam int StOut     = StPct0 + PctStages;
    localparam int NumStages = StOut + 1;

    typedef enum logic [2:0] {
        StatNotPresent  = 3'd0,
        StatDischarging = 3'd1,
        StatCharging    = 3'd2,
        StatFull        = 3'd3,
        StatUnknown     = 3'd4
    } bsn_status_t;

    typedef struct packed {
        logic        absent;
        logic        discharging;
        logic        charging;
        logic [31:0] volts;
    } bsn_meta_t;

    typedef struct packed {
        logic [31:0] dmwh;
        logic [31:0] fmwh;
        logic [31:0] rate;
    } bsn_power_t;

endpackage

`default_nettype wire

### hw/rtl/bsn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsn_front
    import bsn_pkg::*;
(
    input  logic                           clk,
    input  logic [StMul:0]                 en,
    input  logic                           presence_known,
    input  logic [7:0]                     presence_word,
    input  logic                           cap_unit,
    input  logic [31:0]                    design_capacity,
    input  logic [31:0]                    last_full_capacity,
    input  logic [31:0]                    design_voltage,
    input  logic [7:0]                     charge_state,
    input  logic [31:0]                    present_rate,
    input  logic [31:0]                    remaining_capacity,
    input  logic [31:0]                    present_voltage,
    output logic [NumLanes-1:0][63:0]      prod,
    output bsn_meta_t                      meta
);

    logic                         pv_ok;
    logic [31:0]                  chosen;
    logic [31:0]                  volts;
    bsn_meta_t                    meta_s0_next;
    bsn_meta_t                    meta_s0_reg;
    bsn_meta_t                    meta_reg;
    logic [31:0]                  scale_next;
    logic [31:0]                  scale_reg;
    logic [NumLanes-1:0][31:0]    val_next;
    logic [NumLanes-1:0][31:0]    val_reg;
    logic [NumLanes-1:0][63:0]    prod_next;
    logic [NumLanes-1:0][63:0]    prod_reg;

    // Unknown and zero both read as zero
    function automatic logic [31:0] clean32(input logic [31:0] v);
        return ((v == Unknown32) || (v == '0)) ? '0 : v;
    endfunction

    // Pick the voltage, clean the values, choose the scale factor
    always_comb
    begin
        pv_ok  = (present_voltage != '0) && (present_voltage != Unknown32);
        chosen = pv_ok ? present_voltage : design_voltage;
        volts  = (chosen == Unknown32) ? '0 : chosen;

        meta_s0_next.absent      = presence_known & ~presence_word[PresentBit];
        meta_s0_next.discharging = charge_state[0];
        meta_s0_next.charging    = charge_state[1];
        meta_s0_next.volts       = volts;

        // Milliwatt values go through the same path scaled by 1000
        scale_next = cap_unit ? volts : Milli;

        val_next[LaneDesign] = clean32(design_capacity);
        val_next[LaneFull]   = clean32(last_full_capacity);
        val_next[LaneRemain] = clean32(remaining_capacity);
        val_next[LaneRate]   = clean32(present_rate);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            meta_s0_reg <= meta_s0_next;
            scale_reg   <= scale_next;
            val_reg     <= val_next;
        end
    end

    // Scale every lane by the chosen factor
    always_comb
    begin
        for (int l = 0; l < NumLanes; l++)
        begin
            prod_next[l] = 64'(val_reg[l]) * 64'(scale_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[StMul])
        begin
            meta_reg <= meta_s0_reg;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
    assign meta = meta_reg;

endmodule

`default_nettype wire

### hw/rtl/bsn_div1000.sv
`timescale 1ns / 1ps
`default_nettype none

module bsn_div1000
    import bsn_pkg::*;
(
    input  logic                 clk,
    input  logic [DivStages-1:0] en,
    input  logic [63:0]          prod,
    output logic [31:0]          quot
);

    localparam logic [DivXW-1:0] MilliX = DivXW'(Milli);

    logic [DivXW-1:0]  x_reg     [DivSteps];
    logic [DigitW-1:0] q_reg     [DivSteps];
    logic [RemW-1:0]   r_reg     [DivSteps];
    logic [63:0]       pa_reg    [DivSteps];
    logic [63:0]       pb_reg    [DivSteps];
    logic [31:0]       acc_a_reg [DivSteps];
    logic [31:0]       acc_b_reg [DivSteps];

    // Long division by 1000, top digit first; keep the two low quotient digits
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_step
        logic [RemW-1:0]          r_in;
        logic [63:0]              p_in;
        logic [31:0]              acc_in;
        logic [DivXW-1:0]         x_next;
        logic [DivXW+RecipW-1:0]  t_next;
        logic [DigitW-1:0]        q_next;
        logic [DivXW-1:0]         rem_next;

        if (k == 0)
        begin : g_first
            assign r_in   = '0;
            assign p_in   = prod;
            assign acc_in = '0;
        end
        else
        begin : g_rest
            assign r_in   = r_reg[k-1];
            assign p_in   = pb_reg[k-1];
            assign acc_in = acc_b_reg[k-1];
        end

        // Estimate the digit quotient by reciprocal multiply
        assign x_next = {r_in, p_in[(DivSteps-1-k)*DigitW +: DigitW]};
        assign t_next = (DivXW+RecipW)'(x_next) * (DivXW+RecipW)'(Recip1000);
        assign q_next = t_next[RecipShift +: DigitW];

        always_ff @(posedge clk)
        begin
            if (en[2*k])
            begin
                x_reg[k]     <= x_next;
                q_reg[k]     <= q_next;
                pa_reg[k]    <= p_in;
                acc_a_reg[k] <= acc_in;
            end
        end

        // Take the remainder and shift the digit into the quotient
        assign rem_next = x_reg[k] - DivXW'(q_reg[k]) * MilliX;

        always_ff @(posedge clk)
        begin
            if (en[2*k+1])
            begin
                r_reg[k]     <= rem_next[RemW-1:0];
                pb_reg[k]    <= pa_reg[k];
                acc_b_reg[k] <= {acc_a_reg[k][DigitW-1:0], q_reg[k]};
            end
        end
    end

    assign quot = acc_b_reg[DivSteps-1];

endmodule

`default_nettype wire

### hw/rtl/bsn_pct.sv
`timescale 1ns / 1ps
`default_nettype none

module bsn_pct
    import bsn_pkg::*;
(
    input  logic                 clk,
    input  logic [PctStages-1:0] en,
    input  logic [31:0]          remain,
    input  logic [31:0]          full,
    output logic [7:0]           pct
);

    logic [PctNumW-1:0] num_next;
    logic [PctNumW-1:0] rem_reg  [PctStages];
    logic [31:0]        f_reg    [PctStages];
    logic [PctQuoW-1:0] quo_reg  [PctStages];
    logic               sat_reg  [PctStages];
    logic               zero_reg [PctStages];

    // Numerator is remaining times 100
    assign num_next = (PctNumW'(remain) << 6) + (PctNumW'(remain) << 5)
                    + (PctNumW'(remain) << 2);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= num_next;
            f_reg[0]    <= full;
            quo_reg[0]  <= '0;
            sat_reg[0]  <= (remain >= full);
            zero_reg[0] <= (full == '0);
        end
    end

    // Restoring division, one quotient bit per stage, top bit first
    for (genvar j = 1; j < PctStages; j++)
    begin : g_bit
        logic [PctNumW-1:0] dvs;
        logic               ge;

        assign dvs = PctNumW'(f_reg[j-1]) << (PctQuoW - j);
        assign ge  = (rem_reg[j-1] >= dvs);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= ge ? (rem_reg[j-1] - dvs) : rem_reg[j-1];
                f_reg[j]    <= f_reg[j-1];
                quo_reg[j]  <= {quo_reg[j-1][PctQuoW-2:0], ge};
                sat_reg[j]  <= sat_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    end

    // Saturate at 100; no percent for a zero full capacity
    always_comb
    begin
        priority if (zero_reg[PctStages-1])
            pct = NoPercent;
        else if (sat_reg[PctStages-1])
            pct = FullPercent;
        else
            pct = 8'(quo_reg[PctStages-1]);
    end

endmodule

`default_nettype wire

### hw/rtl/battery_status_normalizer_top.sv
// Throughput: one request per cycle unless the output stalls; the decode, the
// 32x32 multiplies, the digit-serial divide by 1000 and the bit-per-stage percent
// divider are pipelined. A stalled output holds its result; earlier empty stages
// keep taking requests. Reset (rst_n, asynchronous, active low) clears the stage
// valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module battery_status_normalizer_top
    import bsn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               presence_known,
    input  logic [7:0]         presence_word,
    input  logic               cap_unit,
    input  logic [31:0]        design_capacity,
    input  logic [31:0]        last_full_capacity,
    input  logic [31:0]        design_voltage,
    input  logic [7:0]         charge_state,
    input  logic [31:0]        present_rate,
    input  logic [31:0]        remaining_capacity,
    input  logic [31:0]        present_voltage,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         battery_status,
    output logic [7:0]         percent_charge,
    output logic [31:0]        chosen_voltage,
    output logic [31:0]        design_energy,
    output logic [31:0]        full_energy,
    output logic signed [31:0] rate_mw
);

    logic [NumStages-1:0]       valid_reg;
    logic [NumStages-1:0]       valid_next;
    logic [NumStages-1:0]       en;
    logic [NumLanes-1:0][63:0]  prod;
    logic [NumLanes-1:0][31:0]  quot;
    bsn_meta_t                  meta_s1;
    bsn_meta_t                  meta_reg [StDiv0:StOut-1];
    bsn_power_t                 pow_reg  [StPct0:StOut-1];
    logic [7:0]                 pct_s;
    bsn_meta_t                  m;
    bsn_power_t                 p;
    bsn_status_t                status_next;
    logic [7:0]                 pct_next;
    logic [31:0]                volts_next;
    logic [31:0]                dmwh_next;
    logic [31:0]                fmwh_next;
    logic [31:0]                rate_next;
    bsn_status_t                status_reg;
    logic [7:0]                 pct_reg;
    logic [31:0]                volts_reg;
    logic [31:0]                dmwh_reg;
    logic [31:0]                fmwh_reg;
    logic [31:0]                rate_reg;

    // A stage loads when the output is ready, or when it or some later stage is empty
    for (genvar i = 0; i < NumStages; i++)
    begin : g_ready
        assign en[i] = out_ready | ~(&valid_reg[NumStages-1:i]);
    end

    // Advance valid bits with their stages
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NumStages; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[StOut];

    bsn_front u_front (
        .clk                (clk),
        .en                 (en[StMul:0]),
        .presence_known     (presence_known),
        .presence_word      (presence_word),
        .cap_unit           (cap_unit),
        .design_capacity    (design_capacity),
        .last_full_capacity (last_full_capacity),
        .design_voltage     (design_voltage),
        .charge_state       (charge_state),
        .present_rate       (present_rate),
        .remaining_capacity (remaining_capacity),
        .present_voltage    (present_voltage),
        .prod               (prod),
        .meta               (meta_s1)
    );

    for (genvar l = 0; l < NumLanes; l++)
    begin : g_lane
        bsn_div1000 u_div (
            .clk  (clk),
            .en   (en[StDiv0 +: DivStages]),
            .prod (prod[l]),
            .quot (quot[l])
        );
    end

    bsn_pct u_pct (
        .clk    (clk),
        .en     (en[StPct0 +: PctStages]),
        .remain (quot[LaneRemain]),
        .full   (quot[LaneFull]),
        .pct    (pct_s)
    );

    // Carry the report flags and voltage alongside the divide and percent stages
    for (genvar i = StDiv0; i < StOut; i++)
    begin : g_meta
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                if (i == StDiv0)
                    meta_reg[i] <= meta_s1;
                else
                    meta_reg[i] <= meta_reg[(i == StDiv0) ? i : i-1];
            end
        end
    end

    // Carry the converted values alongside the percent stages
    for (genvar i = StPct0; i < StOut; i++)
    begin : g_pow
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                if (i == StPct0)
                    pow_reg[i] <= '{dmwh: quot[LaneDesign], fmwh: quot[LaneFull],
                                    rate: quot[LaneRate]};
                else
                    pow_reg[i] <= pow_reg[(i == StPct0) ? i : i-1];
            end
        end
    end

    assign m = meta_reg[StOut-1];
    assign p = pow_reg[StOut-1];

    // Build the status and signed rate; an absent battery reads as all zeros
    always_comb
    begin
        status_next = StatUnknown;
        pct_next    = pct_s;
        volts_next  = m.volts;
        dmwh_next   = p.dmwh;
        fmwh_next   = p.fmwh;
        rate_next   = '0;
        priority if (m.absent)
        begin
            status_next = StatNotPresent;
            pct_next    = '0;
            volts_next  = '0;
            dmwh_next   = '0;
            fmwh_next   = '0;
        end
        else if (m.discharging)
        begin
            status_next = StatDischarging;
            rate_next   = 32'd0 - p.rate;
        end
        else if (m.charging)
        begin
            status_next = StatCharging;
            rate_next   = p.rate;
        end
        else if ((pct_s != NoPercent) && (pct_s >= FullThreshold))
        begin
            status_next = StatFull;
        end
        else
        begin
            status_next = StatUnknown;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[StOut])
        begin
            status_reg <= status_next;
            pct_reg    <= pct_next;
            volts_reg  <= volts_next;
            dmwh_reg   <= dmwh_next;
            fmwh_reg   <= fmwh_next;
            rate_reg   <= rate_next;
        end
    end

    assign battery_status = status_reg;
    assign percent_charge = pct_reg;
    assign chosen_voltage = volts_reg;
    assign design_energy  = dmwh_reg;
    assign full_energy    = fmwh_reg;
    assign rate_mw        = $signed(rate_reg);

endmodule

`default_nettype wire

### hw/rtl/bsn_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bsn_checker
    import bsn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         battery_status,
    input  logic [7:0]         percent_charge,
    input  logic [31:0]        chosen_voltage,
    input  logic [31:0]        design_energy,
    input  logic [31:0]        full_energy,
    input  logic signed [31:0] rate_mw
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(battery_status)
            && $stable(percent_charge) && $stable(rate_mw))
        else $error("stalled result changed");

    // Drop every field for an absent battery
    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (battery_status == StatNotPresent) |-> (percent_charge == '0)
            && (chosen_voltage == '0) && (design_energy == '0) && (full_energy == '0)
            && (rate_mw == '0))
        else $error("absent battery with nonzero fields");

    // No rate unless charging or discharging
    a_idle_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((battery_status == StatFull) || (battery_status == StatUnknown))
            |-> (rate_mw == '0))
        else $error("idle battery with nonzero rate");

    // Percent never passes 100 unless it is the no-percent code
    a_pct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (percent_charge != NoPercent) |-> (percent_charge <= FullPercent))
        else $error("percent above 100");

    // Full only at or above the threshold
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (battery_status == StatFull) |-> (percent_charge >= FullThreshold)
            && (percent_charge != NoPercent))
        else $error("full status below threshold");

endmodule

bind battery_status_normalizer_top bsn_checker u_chk (.*);

`default_nettype wire

### tb/battery_status_normalizer_top_tb.sv
`timescale 1ns / 1ps

module battery_status_normalizer_top_tb;
    import bsn_pkg::*;

    localparam int RandomReports = 1250;
    localparam int StallLimit    = 2000;
    localparam int DrainCycles   = 40;
    localparam int HoldOffCycles = 200;
    localparam int HoldOffAfter  = 300;
    localparam int IdlePercent   = 23;
    localparam int QuietFirst    = 500;
    localparam int QuietLast     = 800;

    typedef struct packed {
        logic        presence_known;
        logic [7:0]  presence_word;
        logic        cap_unit;
        logic [31:0] design_capacity;
        logic [31:0] last_full_capacity;
        logic [31:0] design_voltage;
        logic [7:0]  charge_state;
        logic [31:0] present_rate;
        logic [31:0] remaining_capacity;
        logic [31:0] present_voltage;
    } battery_report_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  percent;
        logic [31:0] volts;
        logic [31:0] design_energy;
        logic [31:0] full_energy;
        logic [31:0] rate;
    } battery_summary_t;

    // Decode reports into expected summaries and match them against the outputs
    class summary_scoreboard;
        battery_summary_t expected_q[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Zero and unknown read as nothing; milliamp values scale by volts / 1000
        function logic [31:0] to_mwh(logic [31:0] v, logic milliamp, logic [31:0] volts);
            logic [63:0] prod;
            if (v == Unknown32 || v == 32'd0)
                return 32'd0;
            if (!milliamp)
                return v;
            prod = 64'(v) * 64'(volts);
            return 32'(prod / 64'(Milli));
        endfunction

        function battery_summary_t decode_report(battery_report_t r);
            battery_summary_t s;
            logic [31:0]      chosen;
            logic [31:0]      volts;
            logic [31:0]      remain_mwh;
            logic [63:0]      ratio;
            logic [63:0]      prod;
            logic [31:0]      rate32;
            s = '0;
            s.status = StatNotPresent;
            if (r.presence_known && !r.presence_word[PresentBit])
                return s;

            // Prefer the measured voltage when it is known
            chosen = (r.present_voltage != 32'd0 && r.present_voltage != Unknown32) ?
                     r.present_voltage : r.design_voltage;
            volts = (chosen == Unknown32) ? 32'd0 : chosen;
            s.volts = volts;
            s.design_energy = to_mwh(r.design_capacity, r.cap_unit, volts);
            s.full_energy = to_mwh(r.last_full_capacity, r.cap_unit, volts);
            remain_mwh = to_mwh(r.remaining_capacity, r.cap_unit, volts);

            if (s.full_energy != 32'd0)
            begin
                ratio = (64'(remain_mwh) * 64'd100) / 64'(s.full_energy);
                s.percent = (ratio > 64'(FullPercent)) ? FullPercent : 8'(ratio);
            end
            else
            begin
                s.percent = NoPercent;
            end

            rate32 = 32'd0;
            if (r.present_rate != Unknown32)
            begin
                if (r.cap_unit)
                begin
                    prod = 64'(r.present_rate) * 64'(volts);
                    rate32 = 32'(prod / 64'(Milli));
                end
                else
                begin
                    rate32 = r.present_rate;
                end
            end

            // Discharging wins over charging; idle rate reads as zero
            if (r.charge_state[0])
            begin
                s.status = StatDischarging;
                rate32 = 32'd0 - rate32;
            end
            else if (r.charge_state[1])
            begin
                s.status = StatCharging;
            end
            else
            begin
                s.status = (s.percent != NoPercent && s.percent >= FullThreshold) ?
                           StatFull : StatUnknown;
                rate32 = 32'd0;
            end
            s.rate = rate32;
            return s;
        endfunction

        function void note_request(battery_report_t r);
            expected_q.push_back(decode_report(r));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(battery_summary_t got);
            battery_summary_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with no request pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("battery_status got %0d want %0d",
                                          got.status, want.status));
            if (got.percent != want.percent)
                report_mismatch($sformatf("percent_charge got %0d want %0d",
                                          got.percent, want.percent));
            if (got.volts != want.volts)
                report_mismatch($sformatf("chosen_voltage got %h want %h",
                                          got.volts, want.volts));
            if (got.design_energy != want.design_energy)
                report_mismatch($sformatf("design_energy got %h want %h",
                                          got.design_energy, want.design_energy));
            if (got.full_energy != want.full_energy)
                report_mismatch($sformatf("full_energy got %h want %h",
                                          got.full_energy, want.full_energy));
            if (got.rate != want.rate)
                report_mismatch($sformatf("rate_mw got %h want %h", got.rate, want.rate));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         battery_status;
    logic [7:0]         percent_charge;
    logic [31:0]        chosen_voltage;
    logic [31:0]        design_energy;
    logic [31:0]        full_energy;
    logic signed [31:0] rate_mw;
    battery_report_t    stim;
    battery_summary_t   seen;

    summary_scoreboard  sb;
    int                 accepted_count;
    bit                 quiet;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        stim = '0;
        accepted_count = 0;
        quiet = 1'b0;
        sb = new();
    end

    always #1 clk = ~clk;

    battery_status_normalizer_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .presence_known     (stim.presence_known),
        .presence_word      (stim.presence_word),
        .cap_unit           (stim.cap_unit),
        .design_capacity    (stim.design_capacity),
        .last_full_capacity (stim.last_full_capacity),
        .design_voltage     (stim.design_voltage),
        .charge_state       (stim.charge_state),
        .present_rate       (stim.present_rate),
        .remaining_capacity (stim.remaining_capacity),
        .present_voltage    (stim.present_voltage),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .battery_status     (battery_status),
        .percent_charge     (percent_charge),
        .chosen_voltage     (chosen_voltage),
        .design_energy      (design_energy),
        .full_energy        (full_energy),
        .rate_mw            (rate_mw)
    );

    assign seen = {battery_status, percent_charge, chosen_voltage, design_energy,
                   full_energy, rate_mw};

    // Check every accepted result against the oldest pending request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(seen);
    end

    // Drive out_ready: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && accepted_count >= HoldOffAfter)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HoldOffCycles) @(negedge clk);
            end
            out_ready <= quiet || ($urandom_range(99) >= IdlePercent);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("** battery_status_normalizer_top: FAILED **");
        $finish;
    end

    function automatic battery_report_t mk(logic known, logic [7:0] word, logic unit,
                                           logic [31:0] dcap, logic [31:0] lfull,
                                           logic [31:0] dvolt, logic [7:0] cstate,
                                           logic [31:0] rate, logic [31:0] remain,
                                           logic [31:0] pvolt);
        battery_report_t r;
        r.presence_known = known;
        r.presence_word = word;
        r.cap_unit = unit;
        r.design_capacity = dcap;
        r.last_full_capacity = lfull;
        r.design_voltage = dvolt;
        r.charge_state = cstate;
        r.present_rate = rate;
        r.remaining_capacity = remain;
        r.present_voltage = pvolt;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return Unknown32;
            2: return Unknown32 - 32'd1;
            3: return $urandom_range(1, 1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_voltage();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return Unknown32;
            2: return pick_word();
            default: return $urandom_range(9000, 17000);
        endcase
    endfunction

    // Build a plausible report most of the time, with edge values mixed in
    function automatic battery_report_t random_report();
        battery_report_t r;
        logic [31:0]     full;
        r.presence_known = ($urandom_range(3) != 0);
        r.presence_word = 8'($urandom_range(255));
        if ($urandom_range(9) < 8)
            r.presence_word[PresentBit] = 1'b1;
        r.cap_unit = 1'($urandom_range(1));
        r.present_voltage = pick_voltage();
        r.design_voltage = pick_voltage();
        full = ($urandom_range(9) < 6) ? 32'($urandom_range(1000, 100000)) : pick_word();
        r.last_full_capacity = full;
        case ($urandom_range(9))
            0, 1, 2, 3: r.remaining_capacity = $urandom_range(0, full);
            4, 5: r.remaining_capacity = full - 32'($urandom_range(0, full / 10));
            default: r.remaining_capacity = pick_word();
        endcase
        r.design_capacity = $urandom_range(1) ? full + 32'($urandom_range(0, 5000)) :
                            pick_word();
        r.present_rate = ($urandom_range(9) < 6) ? 32'($urandom_range(0, 6000)) : pick_word();
        r.charge_state = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) :
                         8'($urandom_range(255));
        return r;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and hold until taken
    task automatic send_report(battery_report_t r);
        while (!quiet && $urandom_range(99) < IdlePercent)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        stim <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
        accepted_count++;
        @(negedge clk);
    endtask

    initial
    begin
        battery_report_t directed[$];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Absent battery, presence assumed, voltage fallback and unknowns
        directed.push_back(mk(1'b1, 8'h00, 1'b1, 5000, 4000, 12000, 8'h01, 100, 2000, 11000));
        directed.push_back(mk(1'b1, 8'hEF, 1'b0, 5000, 4000, 12000, 8'h02, 100, 2000, 11000));
        directed.push_back(mk(1'b0, 8'h00, 1'b0, 5000, 4000, 12000, 8'h01, 1500, 2000,
                              11000));
        directed.push_back(mk(1'b1, 8'h1F, 1'b1, 5200, 4800, 11100, 8'h02, 800, 3000, 12000));
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 5000, 5000, 11100, 8'h02, 500, 4000, 0));
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 5000, 5000, 11100, 8'h01, 500, 4000,
                              Unknown32));
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 5000, 5000, Unknown32, 8'h00, 500, 4000,
                              Unknown32));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 5000, 5000, 12000, 8'h01, Unknown32, 4000,
                              11000));
        // Rate overflow, charge bit combinations
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 3000, 3000, 12000, 8'h02, 32'hFFFF_FFFE,
                              1500, 32'hFFFF_FFFE));
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 3000, 3000, 12000, 8'h01, 32'hFFFF_FFFE,
                              1500, 32'hFFFF_FFFE));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 3000, 3000, 12000, 8'h03, 2500, 1500, 11000));
        // Full threshold edges
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, 1000, 12000, 8'h00, 700, 950, 11000));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, 1000, 12000, 8'h00, 700, 1000, 11000));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, 1000, 12000, 8'h00, 700, 949, 11000));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, 1000, 12000, 8'h00, 700, 1500, 11000));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, 0, 12000, 8'h00, 700, 500, 11000));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 1000, Unknown32, 12000, 8'h00, 700, 500,
                              11000));
        // Field extremes
        directed.push_back(mk(1'b1, 8'hFF, 1'b1, Unknown32, Unknown32, Unknown32, 8'hFF,
                              Unknown32, Unknown32, Unknown32));
        directed.push_back(mk(1'b0, 8'h00, 1'b0, 0, 0, 0, 8'h00, 0, 0, 0));
        directed.push_back(mk(1'b1, 8'h10, 1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                              8'hFC, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE));
        directed.push_back(mk(1'b1, 8'h10, 1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 12000, 8'hFD,
                              32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE));
        directed.push_back(mk(1'b0, 8'hEF, 1'b1, 7000, 6500, 14800, 8'h80, 1200, 6300,
                              15100));

        foreach (directed[i])
            send_report(directed[i]);

        // Random reports, with a stretch where neither side idles
        for (int n = 0; n < RandomReports; n++)
        begin
            quiet = (n >= QuietFirst && n < QuietLast);
            send_report(random_report());
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain, then allow stray results to show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (sb.errors == 0)
            $display("** battery_status_normalizer_top: PASSED **");
        else
            $display("** battery_status_normalizer_top: FAILED **");
        $finish;
    end

endmodule

### files.f
hw/rtl/bsn_pkg.sv
hw/rtl/bsn_front.sv
hw/rtl/bsn_div1000.sv
hw/rtl/bsn_pct.sv
hw/rtl/battery_status_normalizer_top.sv
hw/rtl/bsn_checker.sv
tb/battery_status_normalizer_top_tb.sv
